// ----- hw/rtl/rcsc_pkg.sv -----
// rcsc_pkg: word types, channel order and fixed constants of the stick conditioning unit
// no dependencies; imported by rc_stick_conditioning_unit
package rcsc_pkg;

   localparam int NCHAN = 7;
   localparam int NMAIN = 4;

   localparam int ADC_W     = 12;
   localparam int Q_W       = 10;
   localparam int OUT_W     = 11;
   localparam int RAW_W     = 14;
   localparam int SAMPLE_W  = 13;
   localparam int OFF_W     = 12;
   localparam int CAL_SUM_W = 19;
   localparam int CAL_CNT_W = 6;

   // channel order inside a history row and the offset set
   localparam int CH_THROTTLE = 0;
   localparam int CH_PITCH    = 1;
   localparam int CH_YAW      = 2;
   localparam int CH_ROLL     = 3;
   localparam int CH_AUX_ONE  = 4;
   localparam int CH_AUX_TWO  = 5;
   localparam int CH_AUX_THREE = 6;

   localparam logic [OUT_W-1:0] VAL_MIN = 11'd1000;
   localparam logic [OUT_W-1:0] VAL_MAX = 11'd2000;
   localparam logic [OUT_W-1:0] VAL_MID = 11'd1500;
   localparam logic [OUT_W-1:0] DB_LO   = 11'd1450;
   localparam logic [OUT_W-1:0] DB_HI   = 11'd1550;

   localparam logic signed [RAW_W-1:0] RAW_LO = -14'sd4096;
   localparam logic signed [RAW_W-1:0] RAW_HI = 14'sd4095;
   localparam logic signed [RAW_W-1:0] OFF_LO = -14'sd2048;
   localparam logic signed [RAW_W-1:0] OFF_HI = 14'sd2047;
   localparam logic signed [RAW_W-1:0] OFF_CENTRE = 14'sd1500;

   // calibration: mean over 50 scans, divide by reciprocal (exact for |sum| < 2^18)
   localparam int CAL_SAMPLES = 50;
   localparam logic [CAL_CNT_W-1:0] CAL_LAST = 6'd49;
   localparam int CAL_DIV_K = 24;
   localparam int CAL_REC_W = 19;
   localparam logic [CAL_REC_W-1:0] CAL_RECIP =
      CAL_REC_W'(((64'd1 << CAL_DIV_K) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

   typedef struct packed {
      logic [ADC_W-1:0] adc_stick_a;
      logic [ADC_W-1:0] adc_stick_b;
      logic [ADC_W-1:0] adc_yaw;
      logic [ADC_W-1:0] adc_roll;
      logic [ADC_W-1:0] adc_aux_one;
      logic [ADC_W-1:0] adc_aux_two;
      logic [ADC_W-1:0] adc_aux_three;
      logic             cal_request;
   } req_word_type;

   typedef struct packed {
      logic [OUT_W-1:0] throttle_out;
      logic [OUT_W-1:0] pitch_out;
      logic [OUT_W-1:0] yaw_out;
      logic [OUT_W-1:0] roll_out;
      logic [OUT_W-1:0] aux_one_out;
      logic [OUT_W-1:0] aux_two_out;
      logic [OUT_W-1:0] aux_three_out;
      logic             cal_done;
   } rsp_word_type;

   typedef logic [NCHAN-1:0][SAMPLE_W-1:0] hist_row_type;

   function automatic logic [OUT_W-1:0] map_rise(input logic [Q_W-1:0] q);
      return VAL_MIN + OUT_W'(q);
   endfunction

   function automatic logic [OUT_W-1:0] map_fall(input logic [Q_W-1:0] q);
      return VAL_MAX - OUT_W'(q);
   endfunction

endpackage

// ----- hw/rtl/rc_stick_conditioning_unit.sv -----
// rc_stick_conditioning_unit: top level, scaling, offset removal, moving average,
// clamp with centre snap and centre calibration; depends on rcsc_pkg

// Takes one word of seven ADC readings per clock unless the result side stalls or a
// calibration is finishing, and presents one word of seven conditioned channel
// values on the result port through the input register and then the result
// register; the result register lets a new word enter while a finished one waits.
// The moving average keeps FILTER_DEPTH rows of samples in a small memory, one row
// per scan, read one scan ahead; per-row valid bits stand in for clearing it, so no
// clearing pass follows reset. The running-sum divide is a reciprocal multiply per
// channel. When a calibration completes (cal_done set) the unit holds the next scan
// while it forms the new centre offsets from the calibration sums.
module rc_stick_conditioning_unit #(
   parameter int FILTER_DEPTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rcsc_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rcsc_pkg::rsp_word_type rsp_word,
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data
);
   import rcsc_pkg::*;

   localparam int IDX_W = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
   localparam int SUM_W = SAMPLE_W + $clog2(FILTER_DEPTH);
   localparam int DIV_K = SUM_W + $clog2(FILTER_DEPTH) + 1;
   localparam int REC_W = DIV_K + 1;
   localparam int PROD_W = SUM_W + REC_W;
   localparam int CPROD_W = CAL_SUM_W + CAL_REC_W;
   localparam logic [REC_W-1:0] DIV_RECIP =
      REC_W'(((64'd1 << DIV_K) + 64'(FILTER_DEPTH) - 64'd1) / 64'(FILTER_DEPTH));
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FILTER_DEPTH - 1);

   // handshake and stages
   logic         in_vld_ff, in_vld_in;
   req_word_type in_word_ff;
   logic         out_vld_ff, out_vld_in;
   rsp_word_type out_word_ff, out_word_in;
   logic         advance;

   logic stick_mode_ff, stick_mode_in;

   // history memory
   hist_row_type             hist_mem [FILTER_DEPTH];
   hist_row_type             hist_rd_ff;
   hist_row_type             byp_row_ff;
   hist_row_type             new_row;
   hist_row_type             old_row;
   logic                     byp_ff, byp_in;
   logic                     hist_rd_vld_ff, hist_rd_vld_in;
   logic [FILTER_DEPTH-1:0]  row_vld_ff, row_vld_in;
   logic [IDX_W-1:0]         ring_ff, ring_in;

   logic signed [SUM_W-1:0]  run_sum_ff [NCHAN];
   logic signed [SUM_W-1:0]  run_sum_in [NCHAN];

   // calibration
   logic                        cal_act_ff, cal_act_in;
   logic                        cal_fin_ff, cal_fin_in;
   logic [CAL_CNT_W-1:0]        cal_cnt_ff, cal_cnt_in;
   logic signed [CAL_SUM_W-1:0] cal_sum_ff [NMAIN];
   logic signed [CAL_SUM_W-1:0] cal_sum_in [NMAIN];
   logic signed [OFF_W-1:0]     offs_ff [NMAIN];
   logic signed [OFF_W-1:0]     offs_in [NMAIN];
   logic signed [OFF_W-1:0]     offs_new [NMAIN];
   logic                        cal_done;

   // datapath
   logic [OUT_W-1:0]           base [NCHAN];
   logic signed [RAW_W-1:0]    raw [NCHAN];
   logic signed [SAMPLE_W-1:0] samp [NCHAN];
   logic signed [SUM_W-1:0]    sum_new [NCHAN];
   logic                       sum_neg [NCHAN];
   logic [SUM_W-1:0]           sum_mag [NCHAN];
   logic [PROD_W-1:0]          prod [NCHAN];
   logic [SAMPLE_W-1:0]        quo [NCHAN];
   logic signed [SAMPLE_W-1:0] filt [NCHAN];
   logic [OUT_W-1:0]           val [NCHAN];

   logic                        c_neg [NMAIN];
   logic [CAL_SUM_W-1:0]        c_mag [NMAIN];
   logic [CPROD_W-1:0]          c_prod [NMAIN];
   logic [SAMPLE_W-1:0]         c_quo [NMAIN];
   logic signed [SAMPLE_W-1:0]  c_mean [NMAIN];
   logic signed [RAW_W-1:0]     c_off [NMAIN];

   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready) && !cal_fin_ff;
   assign req_ready = !in_vld_ff || advance;
   assign rsp_valid = out_vld_ff;
   assign rsp_word  = out_word_ff;

   // input mapping and channel routing
   always_comb begin
      base[CH_THROTTLE] = stick_mode_ff ? map_rise(in_word_ff.adc_stick_a[ADC_W-1:2])
                                        : map_fall(in_word_ff.adc_stick_b[ADC_W-1:2]);
      base[CH_PITCH]    = stick_mode_ff ? map_fall(in_word_ff.adc_stick_b[ADC_W-1:2])
                                        : map_rise(in_word_ff.adc_stick_a[ADC_W-1:2]);
      base[CH_YAW]       = map_rise(in_word_ff.adc_yaw[ADC_W-1:2]);
      base[CH_ROLL]      = map_fall(in_word_ff.adc_roll[ADC_W-1:2]);
      base[CH_AUX_ONE]   = map_fall(in_word_ff.adc_aux_one[ADC_W-1:2]);
      base[CH_AUX_TWO]   = map_fall(in_word_ff.adc_aux_two[ADC_W-1:2]);
      base[CH_AUX_THREE] = map_fall(in_word_ff.adc_aux_three[ADC_W-1:2]);
   end

   // offset removal, filter, clamp and centre snap; offset and snap on the four main channels only
   always_comb begin
      old_row = byp_ff ? byp_row_ff : (hist_rd_vld_ff ? hist_rd_ff : '0);
      for (int c = 0; c < NCHAN; c++) begin
         raw[c] = $signed({3'b000, base[c]});
         if (c < NMAIN) begin
            raw[c] = raw[c] - RAW_W'(offs_ff[c]);
         end
         if (raw[c] < RAW_LO) begin
            samp[c] = SAMPLE_W'(RAW_LO);
         end else if (raw[c] > RAW_HI) begin
            samp[c] = SAMPLE_W'(RAW_HI);
         end else begin
            samp[c] = raw[c][SAMPLE_W-1:0];
         end
         new_row[c] = samp[c];
         sum_new[c] = run_sum_ff[c] - SUM_W'($signed(old_row[c])) + SUM_W'(samp[c]);
         sum_neg[c] = sum_new[c][SUM_W-1];
         sum_mag[c] = sum_neg[c] ? $unsigned(-sum_new[c]) : $unsigned(sum_new[c]);
         prod[c]    = PROD_W'(sum_mag[c]) * PROD_W'(DIV_RECIP);
         quo[c]     = prod[c][DIV_K +: SAMPLE_W];
         filt[c]    = sum_neg[c] ? $signed(-quo[c]) : $signed(quo[c]);
         if (filt[c] < $signed(SAMPLE_W'(VAL_MIN))) begin
            val[c] = VAL_MIN;
         end else if (filt[c] > $signed(SAMPLE_W'(VAL_MAX))) begin
            val[c] = VAL_MAX;
         end else begin
            val[c] = filt[c][OUT_W-1:0];
         end
         if (c < NMAIN && val[c] > DB_LO && val[c] < DB_HI) begin
            val[c] = VAL_MID;
         end
         run_sum_in[c] = advance ? sum_new[c] : run_sum_ff[c];
      end
   end

   // new centre offsets from the finished calibration sums
   always_comb begin
      for (int m = 0; m < NMAIN; m++) begin
         c_neg[m]  = cal_sum_ff[m][CAL_SUM_W-1];
         c_mag[m]  = c_neg[m] ? $unsigned(-cal_sum_ff[m]) : $unsigned(cal_sum_ff[m]);
         c_prod[m] = CPROD_W'(c_mag[m]) * CPROD_W'(CAL_RECIP);
         c_quo[m]  = c_prod[m][CAL_DIV_K +: SAMPLE_W];
         c_mean[m] = c_neg[m] ? $signed(-c_quo[m]) : $signed(c_quo[m]);
         c_off[m]  = RAW_W'(c_mean[m]) - OFF_CENTRE;
         if (c_off[m] < OFF_LO) begin
            offs_new[m] = OFF_W'(OFF_LO);
         end else if (c_off[m] > OFF_HI) begin
            offs_new[m] = OFF_W'(OFF_HI);
         end else begin
            offs_new[m] = c_off[m][OFF_W-1:0];
         end
      end
   end

   // calibration control
   always_comb begin
      cal_act_in = cal_act_ff;
      cal_cnt_in = cal_cnt_ff;
      cal_fin_in = 1'b0;
      cal_done   = 1'b0;
      for (int m = 0; m < NMAIN; m++) begin
         cal_sum_in[m] = cal_sum_ff[m];
         offs_in[m]    = cal_fin_ff ? offs_new[m] : offs_ff[m];
      end
      if (advance) begin
         if (cal_act_ff) begin
            for (int m = 0; m < NMAIN; m++) begin
               cal_sum_in[m] = cal_sum_ff[m] + CAL_SUM_W'(filt[m]);
            end
            if (cal_cnt_ff == CAL_LAST) begin
               cal_act_in = 1'b0;
               cal_cnt_in = '0;
               cal_fin_in = 1'b1;
               cal_done   = 1'b1;
            end else begin
               cal_cnt_in = cal_cnt_ff + 1'b1;
            end
         end else if (in_word_ff.cal_request) begin
            for (int m = 0; m < NMAIN; m++) begin
               cal_sum_in[m] = '0;
               offs_in[m]    = '0;
            end
            cal_cnt_in = '0;
            cal_act_in = 1'b1;
         end
      end
   end

   // ring position, row valid bits and read-ahead control
   always_comb begin
      ring_in    = ring_ff;
      row_vld_in = row_vld_ff;
      if (advance) begin
         ring_in = (ring_ff == LAST_IDX) ? '0 : ring_ff + 1'b1;
         row_vld_in[ring_ff] = 1'b1;
      end
      hist_rd_vld_in = row_vld_in[ring_in];
      byp_in         = advance && (ring_in == ring_ff);
   end

   // stage handshake and result word
   always_comb begin
      in_vld_in     = in_vld_ff;
      out_vld_in    = out_vld_ff;
      stick_mode_in = csr_wr_en ? csr_wr_data : stick_mode_ff;
      if (req_valid && req_ready) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
      if (advance) begin
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
      out_word_in.throttle_out  = val[CH_THROTTLE];
      out_word_in.pitch_out     = val[CH_PITCH];
      out_word_in.yaw_out       = val[CH_YAW];
      out_word_in.roll_out      = val[CH_ROLL];
      out_word_in.aux_one_out   = val[CH_AUX_ONE];
      out_word_in.aux_two_out   = val[CH_AUX_TWO];
      out_word_in.aux_three_out = val[CH_AUX_THREE];
      out_word_in.cal_done      = cal_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff      <= 1'b0;
         out_vld_ff     <= 1'b0;
         stick_mode_ff  <= 1'b1;
         ring_ff        <= '0;
         row_vld_ff     <= '0;
         hist_rd_vld_ff <= 1'b0;
         byp_ff         <= 1'b0;
         cal_act_ff     <= 1'b0;
         cal_fin_ff     <= 1'b0;
         cal_cnt_ff     <= '0;
         for (int c = 0; c < NCHAN; c++) begin
            run_sum_ff[c] <= '0;
         end
         for (int m = 0; m < NMAIN; m++) begin
            cal_sum_ff[m] <= '0;
            offs_ff[m]    <= '0;
         end
      end else begin
         in_vld_ff      <= in_vld_in;
         out_vld_ff     <= out_vld_in;
         stick_mode_ff  <= stick_mode_in;
         ring_ff        <= ring_in;
         row_vld_ff     <= row_vld_in;
         hist_rd_vld_ff <= hist_rd_vld_in;
         byp_ff         <= byp_in;
         cal_act_ff     <= cal_act_in;
         cal_fin_ff     <= cal_fin_in;
         cal_cnt_ff     <= cal_cnt_in;
         for (int c = 0; c < NCHAN; c++) begin
            run_sum_ff[c] <= run_sum_in[c];
         end
         for (int m = 0; m < NMAIN; m++) begin
            cal_sum_ff[m] <= cal_sum_in[m];
            offs_ff[m]    <= offs_in[m];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_word;
      end
      if (advance) begin
         out_word_ff <= out_word_in;
      end
      byp_row_ff <= new_row;
   end

   // sample history, read one scan ahead
   always_ff @(posedge clock) begin
      if (advance) begin
         hist_mem[ring_ff] <= new_row;
      end
      hist_rd_ff <= hist_mem[ring_in];
   end

endmodule

// ----- dv/rc_stick_conditioning_checker.sv -----
// rc_stick_conditioning_checker: watches the scan and result channels of the stick
// conditioning unit, predicts every result word and compares it field by field
// depends on rcsc_pkg; instantiated beside the unit by tb_rc_stick_conditioning_unit
`timescale 1ns / 100ps

module rc_stick_conditioning_checker #(
   parameter int FILTER_DEPTH = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  rcsc_pkg::req_word_type req_word,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rcsc_pkg::rsp_word_type rsp_word,
   input  logic                   csr_wr_en,
   input  logic                   csr_wr_data,
   output int                     fail_count,
   output int                     results_owed
);

   import rcsc_pkg::*;

   localparam int RISE_BASE = 1000;
   localparam int FALL_BASE = 2000;
   localparam int OUT_LOW   = 1000;
   localparam int OUT_HIGH  = 2000;
   localparam int SNAP_LOW  = 1450;
   localparam int SNAP_HIGH = 1550;
   localparam int SNAP_MID  = 1500;

   logic                        mode_q;
   logic signed [SAMPLE_W-1:0]  hist [NCHAN][FILTER_DEPTH];
   logic signed [16:0]          run_sum [NCHAN];
   logic [3:0]                  slot;
   logic signed [OFF_W-1:0]     centre [NMAIN];
   logic                        cal_busy;
   logic [CAL_CNT_W-1:0]        cal_count;
   logic signed [CAL_SUM_W-1:0] cal_acc [NMAIN];
   rsp_word_type                scan_results_due [$];
   int                          mismatches = 0;

   function automatic int clip(input int v, input int lo, input int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic rsp_word_type condition_scan(input req_word_type w);
      int           qa, qb;
      int           raw [NCHAN];
      int           filt [NCHAN];
      int           smp, lvl, c;
      logic [OUT_W-1:0] outs [NCHAN];
      rsp_word_type r;
      qa = int'(w.adc_stick_a[ADC_W-1:2]);
      qb = int'(w.adc_stick_b[ADC_W-1:2]);
      if (mode_q) begin
         raw[CH_THROTTLE] = RISE_BASE + qa - int'(centre[CH_THROTTLE]);
         raw[CH_PITCH]    = FALL_BASE - qb - int'(centre[CH_PITCH]);
      end else begin
         raw[CH_PITCH]    = RISE_BASE + qa - int'(centre[CH_PITCH]);
         raw[CH_THROTTLE] = FALL_BASE - qb - int'(centre[CH_THROTTLE]);
      end
      raw[CH_YAW]  = RISE_BASE + int'(w.adc_yaw[ADC_W-1:2]) - int'(centre[CH_YAW]);
      raw[CH_ROLL] = FALL_BASE - int'(w.adc_roll[ADC_W-1:2]) - int'(centre[CH_ROLL]);
      raw[CH_AUX_ONE]   = FALL_BASE - int'(w.adc_aux_one[ADC_W-1:2]);
      raw[CH_AUX_TWO]   = FALL_BASE - int'(w.adc_aux_two[ADC_W-1:2]);
      raw[CH_AUX_THREE] = FALL_BASE - int'(w.adc_aux_three[ADC_W-1:2]);

      if (slot >= FILTER_DEPTH) slot = '0;
      for (c = 0; c < NCHAN; c++) begin
         smp = clip(raw[c], -4096, 4095);
         run_sum[c] = 17'(int'(run_sum[c]) - int'(hist[c][slot]) + smp);
         hist[c][slot] = SAMPLE_W'(smp);
         filt[c] = int'(run_sum[c]) / FILTER_DEPTH;
      end
      slot = slot + 1'b1;
      if (slot >= FILTER_DEPTH) slot = '0;

      r.cal_done = 1'b0;
      if (cal_busy) begin
         for (c = 0; c < NMAIN; c++) cal_acc[c] = CAL_SUM_W'(int'(cal_acc[c]) + filt[c]);
         cal_count = cal_count + 1'b1;
         if (cal_count >= CAL_SAMPLES) begin
            for (c = 0; c < NMAIN; c++)
               centre[c] = OFF_W'(clip(int'(cal_acc[c]) / CAL_SAMPLES - SNAP_MID, -2048, 2047));
            cal_busy   = 1'b0;
            cal_count  = '0;
            r.cal_done = 1'b1;
         end
      end else if (w.cal_request) begin
         for (c = 0; c < NMAIN; c++) begin
            centre[c]  = '0;
            cal_acc[c] = '0;
         end
         cal_count = '0;
         cal_busy  = 1'b1;
      end

      for (c = 0; c < NCHAN; c++) begin
         lvl = clip(filt[c], OUT_LOW, OUT_HIGH);
         if (c < NMAIN && lvl > SNAP_LOW && lvl < SNAP_HIGH) lvl = SNAP_MID;
         outs[c] = OUT_W'(lvl);
      end
      r.throttle_out  = outs[CH_THROTTLE];
      r.pitch_out     = outs[CH_PITCH];
      r.yaw_out       = outs[CH_YAW];
      r.roll_out      = outs[CH_ROLL];
      r.aux_one_out   = outs[CH_AUX_ONE];
      r.aux_two_out   = outs[CH_AUX_TWO];
      r.aux_three_out = outs[CH_AUX_THREE];
      return r;
   endfunction

   task automatic check_field(input string name, input logic [OUT_W-1:0] want,
                              input logic [OUT_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : scoreboard
      rsp_word_type due;
      if (reset) begin
         mode_q = 1'b1;
         for (int c = 0; c < NCHAN; c++) begin
            run_sum[c] = '0;
            for (int d = 0; d < FILTER_DEPTH; d++) hist[c][d] = '0;
         end
         for (int c = 0; c < NMAIN; c++) begin
            centre[c]  = '0;
            cal_acc[c] = '0;
         end
         slot      = '0;
         cal_busy  = 1'b0;
         cal_count = '0;
         scan_results_due.delete();
      end else begin
         if (csr_wr_en) mode_q = csr_wr_data;
         if (req_valid && req_ready) scan_results_due.push_back(condition_scan(req_word));
         if (rsp_valid && rsp_ready) begin
            if (scan_results_due.size() == 0) begin
               $error("result word with none expected");
               mismatches++;
            end else begin
               due = scan_results_due.pop_front();
               check_field("throttle_out", due.throttle_out, rsp_word.throttle_out);
               check_field("pitch_out", due.pitch_out, rsp_word.pitch_out);
               check_field("yaw_out", due.yaw_out, rsp_word.yaw_out);
               check_field("roll_out", due.roll_out, rsp_word.roll_out);
               check_field("aux_one_out", due.aux_one_out, rsp_word.aux_one_out);
               check_field("aux_two_out", due.aux_two_out, rsp_word.aux_two_out);
               check_field("aux_three_out", due.aux_three_out, rsp_word.aux_three_out);
               check_field("cal_done", due.cal_done, rsp_word.cal_done);
            end
         end
      end
      results_owed <= scan_results_due.size();
      fail_count   <= mismatches;
   end

endmodule

// ----- dv/tb_rc_stick_conditioning_unit.sv -----
// tb_rc_stick_conditioning_unit: drives scans, stick mode writes and result stalls
// into the stick conditioning unit and gives the verdict from the checker's count
// depends on rcsc_pkg, rc_stick_conditioning_unit and rc_stick_conditioning_checker
`timescale 1ns / 100ps

module tb_rc_stick_conditioning_unit;

   import rcsc_pkg::*;

   localparam int FILTER_DEPTH = 8;
   localparam int HALF_PERIOD  = 5;

   typedef enum int {
      SPREAD_FULL,
      SPREAD_CENTRE,
      SPREAD_EDGE,
      SPREAD_MIXED
   } spread_type;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_valid   = 1'b0;
   logic         req_ready;
   req_word_type req_word    = '0;
   logic         rsp_valid;
   logic         rsp_ready   = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_wr_en   = 1'b0;
   logic         csr_wr_data = 1'b0;
   logic         calm        = 1'b0;
   int           ready_hold  = 0;
   int           scans_sent  = 0;
   int           fail_count;
   int           results_owed;

   always #(HALF_PERIOD) clock = ~clock;

   rc_stick_conditioning_unit #(
      .FILTER_DEPTH(FILTER_DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   rc_stick_conditioning_checker #(
      .FILTER_DEPTH(FILTER_DEPTH)
   ) i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .results_owed(results_owed)
   );

   function automatic int pick_gap();
      int dice;
      dice = $urandom_range(0, 99);
      if (dice < 60) return 0;
      if (dice < 90) return $urandom_range(1, 3);
      if (dice < 97) return $urandom_range(4, 10);
      return $urandom_range(16, 40);
   endfunction

   function automatic spread_type rand_spread();
      return spread_type'($urandom_range(0, 3));
   endfunction

   function automatic logic [ADC_W-1:0] adc_pick(input spread_type s);
      spread_type k;
      k = (s == SPREAD_MIXED) ? spread_type'($urandom_range(0, 2)) : s;
      case (k)
         SPREAD_CENTRE: return ADC_W'(1748 + $urandom_range(0, 600));
         SPREAD_EDGE: begin
            if ($urandom_range(0, 1)) return ADC_W'(4088 + $urandom_range(0, 7));
            return ADC_W'($urandom_range(0, 7));
         end
         default: return ADC_W'($urandom_range(0, 4095));
      endcase
   endfunction

   function automatic req_word_type make_scan(input spread_type s, input logic ask);
      req_word_type w;
      w.adc_stick_a   = adc_pick(s);
      w.adc_stick_b   = adc_pick(s);
      w.adc_yaw       = adc_pick(s);
      w.adc_roll      = adc_pick(s);
      w.adc_aux_one   = adc_pick(s);
      w.adc_aux_two   = adc_pick(s);
      w.adc_aux_three = adc_pick(s);
      w.cal_request   = ask;
      return w;
   endfunction

   function automatic req_word_type uniform_scan(input logic [ADC_W-1:0] adc, input logic ask);
      return '{adc, adc, adc, adc, adc, adc, adc, ask};
   endfunction

   // result side stalls
   always @(negedge clock) begin : ready_pacing
      int stall;
      stall = calm ? 0 : pick_gap();
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (ready_hold > 0) begin
         rsp_ready  <= 1'b0;
         ready_hold <= ready_hold - 1;
      end else begin
         rsp_ready  <= (stall == 0);
         ready_hold <= (stall > 0) ? stall - 1 : 0;
      end
   end

   task automatic send_scan(input req_word_type w);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      scans_sent++;
   endtask

   // lets the unit settle, including the hold after a calibration
   task automatic drain();
      req_valid <= 1'b0;
      wait (results_owed == 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_mode(input logic m);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_calibration(input spread_type s, input logic poke_end);
      send_scan(make_scan(s, 1'b1));
      for (int k = 1; k <= CAL_SAMPLES; k++)
         send_scan(make_scan(s, (k == CAL_SAMPLES && poke_end) || $urandom_range(0, 9) == 0));
   endtask

   initial begin : stimulus
      req_word_type w;
      int           quota;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      write_mode(1'b1);

      send_scan(uniform_scan('0, 1'b0));
      send_scan(uniform_scan('1, 1'b0));
      send_scan('{12'h000, 12'hFFF, 12'h000, 12'hFFF, 12'h000, 12'hFFF, 12'h000, 1'b0});
      send_scan('{12'hFFF, 12'h000, 12'hFFF, 12'h000, 12'hFFF, 12'h000, 12'hFFF, 1'b0});
      // settle on the snap window edges: 1450, 1550 kept; 1451, 1549 snapped
      w = '{12'd1800, 12'd1800, 12'd1804, 12'd1804, 12'd1800, 12'd1800, 12'd1800, 1'b0};
      repeat (FILTER_DEPTH) send_scan(w);
      send_scan(uniform_scan(12'd2048, 1'b1));
      drain();
      write_mode(1'b0);
      send_scan(uniform_scan('1, 1'b0));
      send_scan(uniform_scan('0, 1'b0));
      send_scan(make_scan(SPREAD_MIXED, 1'b0));

      for (int phase = 0; phase < 4; phase++) begin
         drain();
         write_mode(phase == 3 ? 1'($urandom_range(0, 1)) : 1'(phase % 2));
         quota = scans_sent + 175;
         while (scans_sent < quota) begin
            if ($urandom_range(0, 24) == 0) calm <= ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 15) == 0)
               run_calibration(rand_spread(), 1'($urandom_range(0, 1)));
            else
               send_scan(make_scan(rand_spread(), $urandom_range(0, 59) == 0));
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
